[hw/rtl/cu_pkg.sv]
`default_nettype none

package cu_pkg;

  // default sizes of the binomial table
  localparam int MAX_N_DEF = 63;
  localparam int MAX_K_DEF = 16;

  // field widths
  localparam int SUM_W  = 6;
  localparam int CNT_W  = 5;
  localparam int RANK_W = 63;
  localparam int VAL_W  = 63;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // register select, taken from paddr[2]
  localparam logic REG_TOTAL_SUM  = 1'b0;
  localparam logic REG_PART_COUNT = 1'b1;

  // one result item
  typedef struct packed {
    logic [SUM_W-1:0] part_value;
    logic             last_part;
    logic             rank_error;
  } part_t;

endpackage

`default_nettype wire

[hw/rtl/cu_if.sv]
`default_nettype none

// rank request channel
interface cu_rank_if;
  import cu_pkg::*;
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank_index;

  modport source (output valid, output rank_index, input ready);
  modport sink (input valid, input rank_index, output ready);
endinterface

// part result channel
interface cu_part_if;
  import cu_pkg::*;
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] part_value;
  logic             last_part;
  logic             rank_error;

  modport source (output valid, output part_value, output last_part, output rank_error,
                  input ready);
  modport sink (input valid, input part_value, input last_part, input rank_error,
                output ready);
endinterface

`default_nettype wire

[hw/rtl/composition_unrank_unit.sv]
`default_nettype none

// Weak composition unranking. Each request on rank_in carries a rank t; the unit
// returns the t-th split of total_sum (n) into m = min(part_count, n) ordered
// non-negative parts, one part per result on part_out, the last one marked by
// last_part. A rank not below C(n+m-1, m-1) gives a single result with
// rank_error and last_part set and part_value zero. total_sum and part_count
// are written over the APB port at byte addresses 0 and 4; the user must write
// them only while the unit is idle, as the unit does not enforce it. Zero is
// taken as one and values above MAX_N / MAX_K saturate. After reset the unit
// writes all MAX_N+MAX_K+1 rows (80 by default) of Pascal's triangle into its
// table memory, one row per cycle, and takes no request until that is done.
// A rank then takes a setup read and a range check, then per part a decision
// step and a run of table reads, one binomial per cycle from the single-port
// table. One rank is worked on at a time; a finished result waits in an output
// register, and the unit stalls only when it must emit a second one.
module composition_unrank_unit #(
  parameter int MAX_N = cu_pkg::MAX_N_DEF,
  parameter int MAX_K = cu_pkg::MAX_K_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cu_pkg::ADDR_W-1:0] paddr,
  input  logic [cu_pkg::DATA_W-1:0] pwdata,
  output logic [cu_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  cu_rank_if.sink                   rank_in,
  cu_part_if.source                 part_out
);
  import cu_pkg::*;

  localparam int ROWS  = MAX_N + MAX_K + 1;
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  localparam logic [2:0] S_FILL  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_NEXT  = 3'd3;
  localparam logic [2:0] S_STEP  = 3'd4;

  // configuration registers
  logic [SUM_W-1:0] total_sum;
  logic [CNT_W-1:0] part_count;

  // binomial table, one row of MAX_K columns per entry
  logic [MAX_K-1:0][VAL_W-1:0] bin_mem [ROWS];
  logic [MAX_K-1:0][VAL_W-1:0] rd_q;
  logic [MAX_K-1:0][VAL_W-1:0] prow;
  logic [MAX_K-1:0][VAL_W-1:0] fill_data;
  logic [ROW_W-1:0]            rd_row;
  logic [COL_W-1:0]            rd_col;
  logic                        rd_en;
  logic [ROW_W-1:0]            rd_addr;
  logic [COL_W-1:0]            col_addr;
  logic                        fill_we;
  logic [VAL_W-1:0]            sel_val;

  // sequencer
  logic [2:0]        state, state_next;
  logic [ROW_W-1:0]  fill_row, fill_row_next;
  logic [RANK_W-1:0] t, t_next;
  logic [SUM_W-1:0]  nn, nn_next;
  logic [CNT_W-1:0]  kk, kk_next;
  logic [SUM_W-1:0]  curr, curr_next;
  logic [SUM_W-1:0]  n_sat;
  logic [CNT_W-1:0]  k_sat;
  logic [CNT_W-1:0]  m_sat;

  // output register
  logic  out_valid;
  part_t out_data;
  logic  emit;
  logic  emit_ok;
  part_t emit_data;

  // apb register access
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_sum  <= SUM_W'(1);
      part_count <= CNT_W'(1);
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_TOTAL_SUM:  total_sum  <= pwdata[SUM_W-1:0];
        REG_PART_COUNT: part_count <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TOTAL_SUM:  prdata = DATA_W'(total_sum);
      REG_PART_COUNT: prdata = DATA_W'(part_count);
      default:        prdata = '0;
    endcase
  end

  // clamp the configured total and part count
  always_comb begin
    if (total_sum == '0) begin
      n_sat = SUM_W'(1);
    end else if (total_sum > SUM_W'(MAX_N)) begin
      n_sat = SUM_W'(MAX_N);
    end else begin
      n_sat = total_sum;
    end
    if (part_count == '0) begin
      k_sat = CNT_W'(1);
    end else if (part_count > CNT_W'(MAX_K)) begin
      k_sat = CNT_W'(MAX_K);
    end else begin
      k_sat = part_count;
    end
    m_sat = ({1'b0, k_sat} < n_sat) ? k_sat : CNT_W'(n_sat);
  end

  // next pascal row from the previous one
  always_comb begin
    fill_data[0] = VAL_W'(1);
    for (int c = 1; c < MAX_K; c++) begin
      if (fill_row == '0) begin
        fill_data[c] = '0;
      end else begin
        fill_data[c] = prow[c] + prow[c-1];
      end
    end
  end

  // table memory: write during the fill pass, registered read
  always_ff @(posedge clk) begin
    if (fill_we) begin
      bin_mem[fill_row] <= fill_data;
      prow              <= fill_data;
    end
    if (rd_en) begin
      rd_q   <= bin_mem[rd_addr];
      rd_row <= rd_addr;
      rd_col <= col_addr;
    end
  end

  assign sel_val = rd_q[rd_col];
  assign emit_ok = !out_valid || part_out.ready;

  // unranking sequencer
  always_comb begin
    state_next    = state;
    fill_row_next = fill_row;
    t_next        = t;
    nn_next       = nn;
    kk_next       = kk;
    curr_next     = curr;
    rd_en         = 1'b0;
    rd_addr       = rd_row;
    col_addr      = rd_col;
    fill_we       = 1'b0;
    emit          = 1'b0;
    emit_data     = '0;
    case (state)
      S_FILL: begin
        fill_we       = 1'b1;
        fill_row_next = fill_row + ROW_W'(1);
        if (fill_row == ROW_W'(ROWS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (rank_in.valid) begin
          t_next     = rank_in.rank_index;
          nn_next    = n_sat;
          kk_next    = m_sat;
          curr_next  = '0;
          rd_en      = 1'b1;
          rd_addr    = ROW_W'(n_sat) + ROW_W'(m_sat) - ROW_W'(1);
          col_addr   = COL_W'(m_sat - CNT_W'(1));
          state_next = S_CHECK;
        end
      end
      // rank against the composition count
      S_CHECK: begin
        if (t >= sel_val) begin
          if (emit_ok) begin
            emit                 = 1'b1;
            emit_data.part_value = '0;
            emit_data.last_part  = 1'b1;
            emit_data.rank_error = 1'b1;
            state_next           = S_IDLE;
          end
        end else begin
          state_next = S_NEXT;
        end
      end
      // start a part, or finish one whose value has reached the rest
      S_NEXT: begin
        if (kk == CNT_W'(1)) begin
          if (emit_ok) begin
            emit                 = 1'b1;
            emit_data.part_value = nn;
            emit_data.last_part  = 1'b1;
            emit_data.rank_error = 1'b0;
            state_next           = S_IDLE;
          end
        end else if (curr < nn) begin
          rd_en      = 1'b1;
          rd_addr    = ROW_W'(nn - curr) + ROW_W'(kk) - ROW_W'(2);
          col_addr   = COL_W'(kk - CNT_W'(2));
          state_next = S_STEP;
        end else if (emit_ok) begin
          emit                 = 1'b1;
          emit_data.part_value = curr;
          emit_data.last_part  = 1'b0;
          emit_data.rank_error = 1'b0;
          nn_next              = nn - curr;
          kk_next              = kk - CNT_W'(1);
          curr_next            = '0;
        end
      end
      // one binomial per cycle: subtract and count up, or close the part once the output register can take it
      S_STEP: begin
        if (t < sel_val) begin
          if (emit_ok) begin
            emit                 = 1'b1;
            emit_data.part_value = curr;
            emit_data.last_part  = 1'b0;
            emit_data.rank_error = 1'b0;
            nn_next              = nn - curr;
            kk_next              = kk - CNT_W'(1);
            curr_next            = '0;
            state_next           = S_NEXT;
          end
        end else begin
          t_next    = t - sel_val;
          curr_next = curr + SUM_W'(1);
          if ((curr + SUM_W'(1)) < nn) begin
            rd_en   = 1'b1;
            rd_addr = rd_row - ROW_W'(1);
          end else begin
            state_next = S_NEXT;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_FILL;
      fill_row <= '0;
    end else begin
      state    <= state_next;
      fill_row <= fill_row_next;
    end
  end

  always_ff @(posedge clk) begin
    t    <= t_next;
    nn   <= nn_next;
    kk   <= kk_next;
    curr <= curr_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (part_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= emit_data;
    end
  end

  assign rank_in.ready       = (state == S_IDLE);
  assign part_out.valid      = out_valid;
  assign part_out.part_value = out_data.part_value;
  assign part_out.last_part  = out_data.last_part;
  assign part_out.rank_error = out_data.rank_error;

endmodule

`default_nettype wire
